// File: hdl/rbs_pkg.sv
// rbs_pkg: shared constants, register indexes and types for the ray/box slab test
// used by rbs_div, rbs_lane, rbs_merge and ray_box_slab_test
// no dependencies
package rbs_pkg;

    // fixed-point format
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int DIFF_W    = DATA_W + 1;
    localparam int NUM_W     = DIFF_W + FRAC_BITS;

    // pipeline depths
    localparam int DIV_LAT   = NUM_W + 1;
    localparam int LANE_LAT  = DIV_LAT + 1;
    localparam int NUM_AXES  = 3;

    // configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

    localparam logic signed [DATA_W-1:0] T_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] T_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    // per-axis result of one lane
    typedef struct packed {
        logic signed [DATA_W-1:0] t_near;
        logic signed [DATA_W-1:0] t_far;
        logic                     ok;
    } lane_res_t;

    // per-axis flags carried alongside the dividers
    typedef struct packed {
        logic dir_zero;
        logic dir_neg;
        logic in_slab;
    } lane_side_t;

endpackage

// File: hdl/rbs_div.sv
// rbs_div: pipelined restoring divider, one quotient bit per stage, saturated output
// depends on rbs_pkg
module rbs_div (
    input  logic                                clk,
    input  logic                                en,
    input  logic [rbs_pkg::NUM_W-1:0]           num_mag,
    input  logic [rbs_pkg::DATA_W-1:0]          den_mag,
    input  logic                                neg,
    output logic signed [rbs_pkg::DATA_W-1:0]   quo
);
    import rbs_pkg::*;

    logic [NUM_W-1:0]  nq_reg  [0:NUM_W];
    logic [DATA_W-1:0] rem_reg [0:NUM_W];
    logic [DATA_W-1:0] den_reg [0:NUM_W];
    logic              neg_reg [0:NUM_W];

    // load stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nq_reg[0]  <= num_mag;
            rem_reg[0] <= '0;
            den_reg[0] <= den_mag;
            neg_reg[0] <= neg;
        end
    end

    // one compare and subtract per stage
    for (genvar k = 1; k <= NUM_W; k++)
    begin : g_step
        logic [DATA_W:0]   r2;
        logic              ge;
        logic [DATA_W:0]   diff;
        logic [DATA_W-1:0] rem_next;
        logic [NUM_W-1:0]  nq_next;

        always_comb
        begin
            r2       = {rem_reg[k-1], nq_reg[k-1][NUM_W-1]};
            diff     = r2 - {1'b0, den_reg[k-1]};
            ge       = (r2 >= {1'b0, den_reg[k-1]});
            rem_next = ge ? diff[DATA_W-1:0] : r2[DATA_W-1:0];
            nq_next  = {nq_reg[k-1][NUM_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nq_reg[k]  <= nq_next;
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    // sign and saturation of the final quotient
    logic [NUM_W-1:0]  mag;
    logic              big_pos;
    logic              big_neg;
    logic [DATA_W-1:0] low;

    always_comb
    begin
        mag     = nq_reg[NUM_W];
        low     = mag[DATA_W-1:0];
        big_pos = |mag[NUM_W-1:DATA_W-1];
        big_neg = (|mag[NUM_W-1:DATA_W]) || (mag[DATA_W-1] && (|mag[DATA_W-2:0]));
        if (neg_reg[NUM_W])
            quo = big_neg ? T_MIN : -low;
        else
            quo = big_pos ? T_MAX : low;
    end

endmodule

// File: hdl/rbs_lane.sv
// rbs_lane: entry and exit distance of one axis, two dividers and a swap stage
// depends on rbs_pkg and rbs_div
module rbs_lane (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [rbs_pkg::DATA_W-1:0]  org,
    input  logic signed [rbs_pkg::DATA_W-1:0]  dir,
    input  logic signed [rbs_pkg::DATA_W-1:0]  lo,
    input  logic signed [rbs_pkg::DATA_W-1:0]  hi,
    output rbs_pkg::lane_res_t                 res
);
    import rbs_pkg::*;

    logic signed [DIFF_W-1:0] d_lo;
    logic signed [DIFF_W-1:0] d_hi;
    logic [DIFF_W-1:0]        m_lo;
    logic [DIFF_W-1:0]        m_hi;
    logic [DATA_W-1:0]        den;
    lane_side_t               side_in;

    // exact differences and magnitudes
    always_comb
    begin
        d_lo         = {lo[DATA_W-1], lo} - {org[DATA_W-1], org};
        d_hi         = {hi[DATA_W-1], hi} - {org[DATA_W-1], org};
        m_lo         = d_lo[DIFF_W-1] ? -d_lo : d_lo;
        m_hi         = d_hi[DIFF_W-1] ? -d_hi : d_hi;
        den          = dir[DATA_W-1] ? -dir : dir;
        side_in.dir_zero = (dir == '0);
        side_in.dir_neg  = dir[DATA_W-1];
        side_in.in_slab  = (org >= lo) && (org <= hi);
    end

    logic signed [DATA_W-1:0] q_lo;
    logic signed [DATA_W-1:0] q_hi;

    rbs_div u_div_lo (
        .clk     (clk),
        .en      (en),
        .num_mag ({m_lo, {FRAC_BITS{1'b0}}}),
        .den_mag (den),
        .neg     (d_lo[DIFF_W-1] ^ dir[DATA_W-1]),
        .quo     (q_lo)
    );

    rbs_div u_div_hi (
        .clk     (clk),
        .en      (en),
        .num_mag ({m_hi, {FRAC_BITS{1'b0}}}),
        .den_mag (den),
        .neg     (d_hi[DIFF_W-1] ^ dir[DATA_W-1]),
        .quo     (q_hi)
    );

    // flags follow the dividers
    lane_side_t side_reg [0:DIV_LAT-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < DIV_LAT; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // swap on negative direction, neutral bounds on zero direction
    lane_res_t res_next;
    lane_res_t res_reg;

    always_comb
    begin
        if (side_reg[DIV_LAT-1].dir_zero)
        begin
            res_next.t_near = T_MIN;
            res_next.t_far  = T_MAX;
            res_next.ok     = side_reg[DIV_LAT-1].in_slab;
        end
        else if (side_reg[DIV_LAT-1].dir_neg)
        begin
            res_next.t_near = q_hi;
            res_next.t_far  = q_lo;
            res_next.ok     = 1'b1;
        end
        else
        begin
            res_next.t_near = q_lo;
            res_next.t_far  = q_hi;
            res_next.ok     = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// File: hdl/rbs_merge.sv
// rbs_merge: narrows the ray interval with the three lane results, two stages
// depends on rbs_pkg
module rbs_merge (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_vld,
    input  logic signed [rbs_pkg::DATA_W-1:0]  t_lo,
    input  logic signed [rbs_pkg::DATA_W-1:0]  t_hi,
    input  rbs_pkg::lane_res_t                 lanes [rbs_pkg::NUM_AXES],
    output logic                               out_vld,
    output logic                               out_hit
);
    import rbs_pkg::*;

    logic signed [DATA_W-1:0] near_a_reg, near_b_reg, far_a_reg, far_b_reg;
    logic signed [DATA_W-1:0] near_a_next, near_b_next, far_a_next, far_b_next;
    logic                     ok_reg, ok_next;
    logic                     vld1_reg, vld2_reg;
    logic                     hit_reg, hit_next;
    logic signed [DATA_W-1:0] near_f, far_f;

    // first level: pairwise max of entries, min of exits
    always_comb
    begin
        near_a_next = (lanes[0].t_near > t_lo) ? lanes[0].t_near : t_lo;
        near_b_next = (lanes[2].t_near > lanes[1].t_near) ? lanes[2].t_near
                                                          : lanes[1].t_near;
        far_a_next  = (lanes[0].t_far < t_hi) ? lanes[0].t_far : t_hi;
        far_b_next  = (lanes[2].t_far < lanes[1].t_far) ? lanes[2].t_far
                                                        : lanes[1].t_far;
        ok_next     = lanes[0].ok && lanes[1].ok && lanes[2].ok;
    end

    // second level: final bounds and hit decision
    always_comb
    begin
        near_f   = (near_b_reg > near_a_reg) ? near_b_reg : near_a_reg;
        far_f    = (far_b_reg < far_a_reg) ? far_b_reg : far_a_reg;
        hit_next = ok_reg && (far_f > near_f);
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            near_a_reg <= near_a_next;
            near_b_reg <= near_b_next;
            far_a_reg  <= far_a_next;
            far_b_reg  <= far_b_next;
            ok_reg     <= ok_next;
            hit_reg    <= hit_next;
        end
    end

    // valid stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
        end
    end

    assign out_vld = vld2_reg;
    assign out_hit = hit_reg;

endmodule

// File: hdl/ray_box_slab_test.sv
// ray_box_slab_test: top level, configuration registers, three axis lanes and merge
// depends on rbs_pkg, rbs_lane, rbs_merge
//
// Usage:
//   The box corners sit in six 32-bit signed Q16.16 registers written through
//   cfg_we / cfg_addr / cfg_wdata (index 0..2 lower corner x,y,z, 3..5 upper
//   corner x,y,z; higher indexes are ignored). Write them only while idle.
//   Rays arrive on a valid/ready channel (origin, direction, t_start, t_end);
//   each transfer produces exactly one hit bit on the out_valid/out_ready
//   channel, in order.
//   The path from input transfer to out_valid is one load stage and 49 one-bit
//   steps of the distance dividers, one swap stage, two merge stages.
//   Throughput is one ray per cycle; the whole pipeline advances together, so
//   a new ray is taken in every cycle in which the output register is empty or
//   is being read.
//   When the receiver stalls with a result waiting, the pipeline freezes and
//   in_ready drops until the result is taken.
//   Reset clears all valid flags and the box registers to zero.
module ray_box_slab_test (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rbs_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [rbs_pkg::DATA_W-1:0]          cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [rbs_pkg::DATA_W-1:0]   origin_x,
    input  logic signed [rbs_pkg::DATA_W-1:0]   origin_y,
    input  logic signed [rbs_pkg::DATA_W-1:0]   origin_z,
    input  logic signed [rbs_pkg::DATA_W-1:0]   dir_x,
    input  logic signed [rbs_pkg::DATA_W-1:0]   dir_y,
    input  logic signed [rbs_pkg::DATA_W-1:0]   dir_z,
    input  logic signed [rbs_pkg::DATA_W-1:0]   t_start,
    input  logic signed [rbs_pkg::DATA_W-1:0]   t_end,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit
);
    import rbs_pkg::*;

    logic signed [DATA_W-1:0] box_min_reg [NUM_AXES];
    logic signed [DATA_W-1:0] box_max_reg [NUM_AXES];

    // box registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                box_min_reg[i] <= '0;
                box_max_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_BOX_MIN_X: box_min_reg[0] <= cfg_wdata;
                REG_BOX_MIN_Y: box_min_reg[1] <= cfg_wdata;
                REG_BOX_MIN_Z: box_min_reg[2] <= cfg_wdata;
                REG_BOX_MAX_X: box_max_reg[0] <= cfg_wdata;
                REG_BOX_MAX_Y: box_max_reg[1] <= cfg_wdata;
                REG_BOX_MAX_Z: box_max_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // global advance: move when the output register is free or being read
    logic adv;
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // valid and interval travel beside the lanes
    logic                     vld_reg  [0:LANE_LAT-1];
    logic signed [DATA_W-1:0] tlo_reg  [0:LANE_LAT-1];
    logic signed [DATA_W-1:0] thi_reg  [0:LANE_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANE_LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < LANE_LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tlo_reg[0] <= t_start;
            thi_reg[0] <= t_end;
            for (int i = 1; i < LANE_LAT; i++)
            begin
                tlo_reg[i] <= tlo_reg[i-1];
                thi_reg[i] <= thi_reg[i-1];
            end
        end
    end

    // one lane per axis
    lane_res_t lane_res [NUM_AXES];

    rbs_lane u_lane_x (
        .clk (clk), .en (adv), .org (origin_x), .dir (dir_x),
        .lo (box_min_reg[0]), .hi (box_max_reg[0]), .res (lane_res[0])
    );

    rbs_lane u_lane_y (
        .clk (clk), .en (adv), .org (origin_y), .dir (dir_y),
        .lo (box_min_reg[1]), .hi (box_max_reg[1]), .res (lane_res[1])
    );

    rbs_lane u_lane_z (
        .clk (clk), .en (adv), .org (origin_z), .dir (dir_z),
        .lo (box_min_reg[2]), .hi (box_max_reg[2]), .res (lane_res[2])
    );

    // interval merge and output register
    rbs_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (vld_reg[LANE_LAT-1]),
        .t_lo    (tlo_reg[LANE_LAT-1]),
        .t_hi    (thi_reg[LANE_LAT-1]),
        .lanes   (lane_res),
        .out_vld (out_valid),
        .out_hit (hit)
    );

`ifndef SYNTHESIS
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg[LANE_LAT-1]))
        else $error("pipeline moved during stall");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted ray not in first stage");

    a_ready_only_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input blocked without a stalled result");
`endif

endmodule
